// ===== rtl/wsd_pkg.sv =====
// Shared codes and controller-to-datapath command type for the work-stealing deque.
package wsd_pkg;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_STEAL = 2'd2;

  localparam logic [1:0] ST_PUSHED   = 2'd0;
  localparam logic [1:0] ST_RETURNED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned COUNT_BITS = 4;

  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // perform the store access and index update
  } wsd_cmd_t;

endpackage

// ===== rtl/wsd_ctrl.sv =====
// Sequencing state machine of the work-stealing deque.
module wsd_ctrl
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output wsd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_RESP;
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_RESP);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.exec   = (state_r == S_EXEC);

endmodule

// ===== rtl/wsd_dpath.sv =====
// Task store, running indices and result registers of the work-stealing deque.
module wsd_dpath
  import wsd_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 4,
  parameter int unsigned TASK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsd_cmd_t              cmd,
  input  logic [1:0]            in_action,
  input  logic [WORD_BITS-1:0]  in_task_in,
  output logic [1:0]            out_status,
  output logic [WORD_BITS-1:0]  out_task_out,
  output logic [COUNT_BITS-1:0] out_entry_count,
  output logic                  out_is_empty
);

  localparam int unsigned DEPTH = 1 << LOG_DEPTH;
  localparam int unsigned IW    = LOG_DEPTH + 1;
  localparam logic [IW-1:0] FULL_CNT = IW'(DEPTH - 1);
  localparam logic [IW-1:0] ONE      = IW'(1);

  logic [1:0]           act_r;
  logic [TASK_BITS-1:0] task_r;
  logic [TASK_BITS-1:0] task_w;
  logic [IW-1:0]        top_r, top_nxt;
  logic [IW-1:0]        bot_r, bot_nxt;
  logic [TASK_BITS-1:0] mem [DEPTH];
  logic [TASK_BITS-1:0] rd_r;
  logic [1:0]           status_r, status_nxt;
  logic [IW-1:0]        cnt;
  logic [IW-1:0]        bot_dec;
  logic [IW-1:0]        top_inc;
  logic [IW-1:0]        rd_idx;
  logic                 do_write;
  logic                 do_read;

  // Handles are masked to TASK_BITS, or zero-extended when it exceeds the word.
  always_comb begin
    for (int i = 0; i < TASK_BITS; i++) begin
      task_w[i] = (i < WORD_BITS) ? in_task_in[i % WORD_BITS] : 1'b0;
    end
  end

  assign cnt     = bot_r - top_r;
  assign bot_dec = bot_r - ONE;
  assign top_inc = top_r + ONE;
  assign rd_idx  = (act_r == ACT_POP) ? bot_dec : top_r;

  always_comb begin
    top_nxt    = top_r;
    bot_nxt    = bot_r;
    status_nxt = ST_EMPTY;
    do_write   = 1'b0;
    do_read    = 1'b0;
    unique case (act_r)
      ACT_PUSH: begin
        if (cnt >= FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          do_write   = 1'b1;
          bot_nxt    = bot_r + ONE;
          status_nxt = ST_PUSHED;
        end
      end
      ACT_POP: begin
        if (cnt != '0) begin
          do_read    = 1'b1;
          status_nxt = ST_RETURNED;
          if (cnt == ONE) begin
            top_nxt = top_inc;
            bot_nxt = top_inc;
          end else begin
            bot_nxt = bot_dec;
          end
        end
      end
      ACT_STEAL: begin
        if (cnt != '0) begin
          do_read    = 1'b1;
          status_nxt = ST_RETURNED;
          top_nxt    = top_inc;
        end
      end
      default: status_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      task_r <= task_w;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      bot_r <= '0;
    end else if (cmd.exec) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      mem[bot_r[LOG_DEPTH-1:0]] <= task_r;
    end
    if (cmd.exec && do_read) begin
      rd_r <= mem[rd_idx[LOG_DEPTH-1:0]];
    end
  end

  assign out_status   = status_r;
  assign out_is_empty = (cnt == '0);

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      out_task_out[i] = (i < TASK_BITS && status_r == ST_RETURNED) ?
                        rd_r[i % TASK_BITS] : 1'b0;
    end
    for (int j = 0; j < COUNT_BITS; j++) begin
      out_entry_count[j] = (j < IW) ? cnt[j % IW] : 1'b0;
    end
  end

endmodule

// ===== rtl/work_stealing_deque.sv =====
// Top level of the work-stealing deque: controller, datapath and checks.
//
// A double-ended task queue held in a ring store of 2**LOG_DEPTH handles.
// The owner pushes and pops at the bottom; thieves steal from the top.
// A word is offered on in_action and in_task_in with start high, and it is
// taken at the clock edge where start is high and busy is low.
// Action codes are push, pop and steal; the unused code leaves the deque
// untouched and reports empty. A push is refused with the full status
// once one entry less than the store depth is held.
// Every word gives exactly one result word, shown on the out_ ports for a
// single cycle while out_strobe is high, once the execute state is done.
// The receiver cannot stall: a result is lost if it is not taken then.
// busy stays high through the execute and response states, so a new word
// is not taken before the result of the last one has been shown; the pace
// is set by the registered store read followed by the response state.
// The task handle is zero unless a task was returned; the entry count
// and empty flag describe the deque after the operation.
// A synchronous active-low reset empties the deque by clearing both
// indices; the store contents are not cleared and are never read
// before being written.
module work_stealing_deque
  import wsd_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 4,
  parameter int unsigned TASK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic [WORD_BITS-1:0]  in_task_in,
  output logic                  out_strobe,
  output logic [1:0]            out_status,
  output logic [WORD_BITS-1:0]  out_task_out,
  output logic [COUNT_BITS-1:0] out_entry_count,
  output logic                  out_is_empty
);

  wsd_cmd_t cmd;

  // The controller sequences capture, execute and response cycles.
  wsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // The datapath owns the store and both running indices.
  wsd_dpath #(
    .LOG_DEPTH (LOG_DEPTH),
    .TASK_BITS (TASK_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_action),
    .in_task_in      (in_task_in),
    .out_status      (out_status),
    .out_task_out    (out_task_out),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

`ifndef SYNTHESIS
  // Each accepted word yields its result strobe after the execute state.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result strobe missing two cycles after acceptance");

  // A result is shown for one cycle only.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // The task handle is zero unless a task was returned.
  a_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_RETURNED) |-> (out_task_out == '0))
    else $error("task handle nonzero without a returned task");
`endif

endmodule
